[src/otwfk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package otwfk_pkg;
    localparam int MaxSteps = 24;
    localparam int AccW = 34;
    localparam logic signed [AccW-1:0] InvGain = 34'sd652032874;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_VEC_INIT,
        CMD_VEC_STEP,
        CMD_VEC_DONE,
        CMD_ROT_INIT,
        CMD_ROT_STEP,
        CMD_ROT_DONE
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [4:0] step;
        logic [1:0] lane;
    } t_ctl;
endpackage
`default_nettype wire

[src/otwfk_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module otwfk_ctrl #(
    parameter int STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire                i_kind,
    input  wire                i_out_busy,
    output logic               o_ready,
    output logic               o_emit,
    output otwfk_pkg::t_ctl    o_ctl
);
    import otwfk_pkg::*;

    localparam logic [4:0] Last = 5'((STEPS > MaxSteps ? MaxSteps : STEPS) - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_VINIT, S_VSTEP, S_RINIT, S_RSTEP, S_RDONE, S_EMIT
    } t_state;

    t_state     r_state;
    logic [4:0] r_step;
    logic [1:0] r_lane;

    assign o_ready = (r_state == S_IDLE);
    assign o_emit  = (r_state == S_EMIT) && !i_out_busy;

    always_comb begin
        o_ctl.cmd  = CMD_NONE;
        o_ctl.step = r_step;
        o_ctl.lane = r_lane;
        unique case (r_state)
            S_IDLE:  if (i_start) o_ctl.cmd = CMD_LOAD;
            S_VINIT: o_ctl.cmd = CMD_VEC_INIT;
            S_VSTEP: o_ctl.cmd = (r_step == Last) ? CMD_VEC_DONE : CMD_VEC_STEP;
            S_RINIT: o_ctl.cmd = CMD_ROT_INIT;
            S_RSTEP: o_ctl.cmd = CMD_ROT_STEP;
            S_RDONE: o_ctl.cmd = CMD_ROT_DONE;
            S_EMIT:  o_ctl.cmd = CMD_NONE;
            default: o_ctl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_lane  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= i_kind ? S_RINIT : S_VINIT;
                    r_lane  <= '0;
                    r_step  <= '0;
                end
                S_VINIT: r_state <= S_VSTEP;
                S_VSTEP: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == Last) r_state <= S_IDLE;
                end
                S_RINIT: begin
                    r_step  <= '0;
                    r_state <= S_RSTEP;
                end
                S_RSTEP: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == Last) r_state <= S_RDONE;
                end
                S_RDONE: begin
                    if (r_lane == 2'd2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_lane  <= r_lane + 2'd1;
                        r_state <= S_RINIT;
                    end
                end
                S_EMIT: if (!i_out_busy) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/otwfk_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module otwfk_dp #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  otwfk_pkg::t_ctl             i_ctl,
    input  wire signed [15:0]           i_qx,
    input  wire signed [15:0]           i_qy,
    input  wire signed [15:0]           i_qz,
    input  wire signed [15:0]           i_qw,
    input  wire signed [19:0]           i_vx,
    input  wire signed [19:0]           i_vy,
    input  wire signed [19:0]           i_w,
    input  wire [22:0]                  i_limit,
    input  wire [7:0]                   i_arm,
    output logic signed [23:0]          o_a,
    output logic signed [23:0]          o_b,
    output logic signed [23:0]          o_c
);
    import otwfk_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] Third = AB'(((64'd1 << AB) + 64'd1) / 64'd3);
    localparam logic [AB-1:0] Sixth = AB'(((64'd1 << AB) + 64'd3) / 64'd6);
    localparam int VW = 36;   // vectoring x/y width
    localparam int SW = 62;   // wheel sum width

    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [19:0] r_vx, r_vy, r_w;
    logic [AB-1:0]      r_head;
    logic signed [VW-1:0] r_x, r_y;
    logic [31:0]        r_acc;
    logic               r_zero;
    logic signed [AccW-1:0] r_cx, r_cy, r_cz;
    logic               r_neg;
    logic signed [SW-1:0] r_sum0, r_sum1, r_sum2;

    logic [4:0] st;
    assign st = i_ctl.step;
    logic [31:0] at;
    assign at = atan_entry(st);

    // quaternion terms, exact with 28 fractional bits
    logic signed [33:0] num, den;
    always_comb begin
        num = 34'(2 * (34'(r_qw) * 34'(r_qz) + 34'(r_qx) * 34'(r_qy)));
        den = 34'sd268435456 - 34'(2 * (34'(r_qy) * 34'(r_qy) + 34'(r_qz) * 34'(r_qz)));
    end

    logic [AB-1:0] ang;
    always_comb begin
        case (i_ctl.lane)
            2'd1:    ang = r_head + Third;
            2'd2:    ang = r_head + Sixth;
            default: ang = r_head;
        endcase
    end
    logic [31:0] a32;
    assign a32 = {ang, {(32 - AB){1'b0}}};

    logic signed [AccW-1:0] cx, cy;
    assign cx = r_neg ? -r_cx : r_cx;
    assign cy = r_neg ? -r_cy : r_cy;

    // wheel terms at 38 fractional bits (30 from cos/sin, 8 from velocity)
    logic signed [SW-1:0] pvx, pvy, rot;
    assign pvx = SW'(r_vx) * SW'(cx);
    assign pvy = SW'(r_vy) * SW'(cy);
    assign rot = (SW'(r_w) * SW'($signed({1'b0, i_arm}))) <<< 30;

    function automatic logic signed [23:0] finish(input logic signed [SW-1:0] s,
                                                  input logic [22:0] lim);
        logic signed [SW-1:0] v, l;
        begin
            v = (s + (SW'(1) <<< 29)) >>> 30;
            l = SW'($signed({1'b0, lim}));
            if (v > l) v = l;
            if (v < -l) v = -l;
            return v[23:0];
        end
    endfunction

    assign o_a = finish(r_sum0, i_limit);
    assign o_b = finish(r_sum1, i_limit);
    assign o_c = finish(r_sum2, i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_qx <= i_qx; r_qy <= i_qy; r_qz <= i_qz; r_qw <= i_qw;
                    r_vx <= i_vx; r_vy <= i_vy; r_w <= i_w;
                end
                CMD_VEC_INIT: begin
                    r_zero <= (num == 0) && (den == 0);
                    if (den < 0) begin
                        r_x <= -VW'(den); r_y <= -VW'(num);
                        r_acc <= 32'h8000_0000;
                    end else begin
                        r_x <= VW'(den); r_y <= VW'(num);
                        r_acc <= '0;
                    end
                end
                CMD_VEC_STEP, CMD_VEC_DONE: begin
                    logic signed [VW-1:0] nx, ny;
                    logic [31:0] na;
                    if (r_y > 0) begin
                        nx = r_x + (r_y >>> st);
                        ny = r_y - (r_x >>> st);
                        na = r_acc + at;
                    end else begin
                        nx = r_x - (r_y >>> st);
                        ny = r_y + (r_x >>> st);
                        na = r_acc - at;
                    end
                    r_x <= nx; r_y <= ny; r_acc <= na;
                    if (i_ctl.cmd == CMD_VEC_DONE) begin
                        logic [32:0] rn;
                        rn = {1'b0, na} + (33'd1 << (31 - AB));
                        r_head <= r_zero ? '0 : rn[31:32-AB];
                    end
                end
                CMD_ROT_INIT: begin
                    logic signed [AccW-1:0] z;
                    z = AccW'($signed(a32));
                    r_cx <= InvGain;
                    r_cy <= '0;
                    if (z > AccW'(32'sh4000_0000)) begin
                        r_cz <= z - AccW'(64'sh8000_0000); r_neg <= 1'b1;
                    end else if (z < -AccW'(32'sh4000_0000)) begin
                        r_cz <= z + AccW'(64'sh8000_0000); r_neg <= 1'b1;
                    end else begin
                        r_cz <= z; r_neg <= 1'b0;
                    end
                end
                CMD_ROT_STEP: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - (r_cy >>> st);
                        r_cy <= r_cy + (r_cx >>> st);
                        r_cz <= r_cz - AccW'(at);
                    end else begin
                        r_cx <= r_cx + (r_cy >>> st);
                        r_cy <= r_cy - (r_cx >>> st);
                        r_cz <= r_cz + AccW'(at);
                    end
                end
                CMD_ROT_DONE: begin
                    case (i_ctl.lane)
                        2'd0:    r_sum0 <= rot - pvx - pvy;
                        2'd1:    r_sum1 <= rot - pvx + pvy;
                        default: r_sum2 <= rot + pvx + pvy;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/omni_three_wheel_field_kinematics_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Three-wheel omni drive inverse kinematics in the field frame. An orientation
// beat (tuser=0) turns a quaternion into a stored heading with a vectoring
// CORDIC and gives no output. A command beat
// (tuser=1) gives one output beat of three clamped wheel speeds; it runs the
// shared rotation CORDIC three times and then waits while the previous output
// beat is still not accepted. The CORDIC step count is capped at 24.
// One item is in work at a time; the result sits in an output register.
module omni_three_wheel_field_kinematics_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // qx, qy, qz, qw (16 each), vel_x, vel_y, rot_rate (20 each), pad
    input  wire [127:0] s_axis_tdata,
    // req_type
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // wheel_speed_a, wheel_speed_b, wheel_speed_c
    output logic [71:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import otwfk_pkg::*;

    localparam logic [2:0] AddrLimit = 3'd0;
    localparam logic [2:0] AddrArm   = 3'd4;

    logic [22:0] r_limit;
    logic [7:0]  r_arm;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 23'd43520;
            r_arm   <= 8'd10;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                AddrLimit: r_limit <= pwdata[22:0];
                AddrArm:   r_arm   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            AddrLimit: prdata = {9'd0, r_limit};
            AddrArm:   prdata = {24'd0, r_arm};
            default:   prdata = '0;
        endcase
    end

    t_ctl ctl;
    logic emit, ready;
    logic signed [23:0] wa, wb, wc;

    otwfk_ctrl #(.STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && ready), .i_kind(s_axis_tuser),
        .i_out_busy(m_axis_tvalid && !m_axis_tready),
        .o_ready(ready), .o_emit(emit), .o_ctl(ctl)
    );
    assign s_axis_tready = ready;

    otwfk_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_qx(s_axis_tdata[15:0]), .i_qy(s_axis_tdata[31:16]),
        .i_qz(s_axis_tdata[47:32]), .i_qw(s_axis_tdata[63:48]),
        .i_vx(s_axis_tdata[83:64]), .i_vy(s_axis_tdata[103:84]),
        .i_w(s_axis_tdata[123:104]),
        .i_limit(r_limit), .i_arm(r_arm),
        .o_a(wa), .o_b(wb), .o_c(wc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (emit) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {wc, wb, wa};
            end
        end
    end
endmodule
`default_nettype wire

[verif/omni_three_wheel_field_kinematics_unit_tb.sv]
`timescale 1ns / 1ps
module omni_three_wheel_field_kinematics_unit_tb;
    import otwfk_pkg::*;

    localparam int NSTEPS     = 16;
    localparam int ANGLE_BITS = 16;
    localparam int CYCLE_LIMIT = 600000;
    // a command runs the rotation CORDIC three times; leave margin past that
    localparam int SETTLE_CYCLES = 3 * (NSTEPS + 2) + 30;
    localparam logic [2:0] ADDR_SPEED_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_ARM_FACTOR  = 3'd4;
    localparam bit REQ_ORIENT  = 1'b0;
    localparam bit REQ_COMMAND = 1'b1;
    localparam longint GAIN_INV = 64'sd652032874;
    localparam longint HALF_TURN = 64'sd2147483648;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint ATAN_STEP [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    typedef struct {
        bit                 req;
        logic signed [15:0] qx, qy, qz, qw;
        logic signed [19:0] vx, vy, rot;
    } t_drive_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    omni_three_wheel_field_kinematics_unit #(
        .CORDIC_STEPS(NSTEPS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [22:0]           pred_limit = 23'd43520;
    logic [7:0]            pred_arm = 8'd10;
    logic [ANGLE_BITS-1:0] pred_heading = '0;

    logic [71:0] wheel_q[$];
    int errors = 0;
    int n_orient = 0;
    int n_cmd = 0;
    int n_wheel_beats = 0;
    int cycles = 0;
    bit idle_on = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    function automatic logic [ANGLE_BITS-1:0] heading_from_quat(longint num, longint den);
        longint x, y, nx;
        logic [63:0] acc;
        if (num == 0 && den == 0) return '0;
        x = den;
        y = num;
        acc = '0;
        if (den < 0) begin
            x = -den;
            y = -num;
            acc = 64'h8000_0000;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                acc = acc + ATAN_STEP[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                acc = acc - ATAN_STEP[i];
            end
            x = nx;
        end
        acc = acc & 64'hFFFF_FFFF;
        acc = acc + (64'd1 << (31 - ANGLE_BITS));
        acc = acc >> (32 - ANGLE_BITS);
        return acc[ANGLE_BITS-1:0];
    endfunction

    task automatic rotate_unit(input logic [ANGLE_BITS-1:0] ang, output longint c,
                               output longint s);
        logic [63:0] a32;
        longint z, x, y, nx;
        bit neg;
        a32 = (64'(ang) << (32 - ANGLE_BITS)) & 64'hFFFF_FFFF;
        z = (a32 < 64'h8000_0000) ? longint'(a32) : longint'(a32) - 2 * HALF_TURN;
        x = GAIN_INV;
        y = 0;
        neg = 1'b0;
        // fold into +-90 deg, flip sign of the result afterwards
        if (z > QUARTER_TURN) begin
            z = z - HALF_TURN;
            neg = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z = z + HALF_TURN;
            neg = 1'b1;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_STEP[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_STEP[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic logic [23:0] clamp_speed(longint sum);
        longint v, lim;
        v = (sum + (64'sd1 <<< 29)) >>> 30;
        lim = longint'({1'b0, pred_limit});
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[23:0];
    endfunction

    task automatic predict_item(input t_drive_item it);
        longint num, den, vx, vy, rot, c0, s0, c1, s1, c2, s2;
        logic [ANGLE_BITS-1:0] third, sixth;
        logic [23:0] wa, wb, wc;
        if (it.req == REQ_ORIENT) begin
            num = 2 * (longint'(it.qw) * it.qz + longint'(it.qx) * it.qy);
            den = (64'sd1 <<< 28) - 2 * (longint'(it.qy) * it.qy + longint'(it.qz) * it.qz);
            pred_heading = heading_from_quat(num, den);
            n_orient++;
        end else begin
            third = ANGLE_BITS'(((1 << ANGLE_BITS) + 1) / 3);
            sixth = ANGLE_BITS'(((1 << ANGLE_BITS) + 3) / 6);
            vx = it.vx;
            vy = it.vy;
            rot = longint'({1'b0, pred_arm}) * longint'(it.rot) * (64'sd1 <<< 30);
            rotate_unit(pred_heading, c0, s0);
            rotate_unit(pred_heading + third, c1, s1);
            rotate_unit(pred_heading + sixth, c2, s2);
            wa = clamp_speed(-vx * c0 - vy * s0 + rot);
            wb = clamp_speed(-vx * c1 + vy * s1 + rot);
            wc = clamp_speed(vx * c2 + vy * s2 + rot);
            wheel_q.push_back({wc, wb, wa});
            n_cmd++;
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output side: random stall bursts plus one requested long hold
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [71:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_wheel_beats++;
            if (wheel_q.size() == 0) begin
                $display("%0t unexpected beat, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = wheel_q.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (m_axis_tdata[24*k +: 24] !== want[24*k +: 24]) begin
                        $display("%0t wheel %0d mismatch: expected %0d actual %0d", $time, k,
                                 $signed(want[24*k +: 24]), $signed(m_axis_tdata[24*k +: 24]));
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_item(input t_drive_item it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.req;
        s_axis_tdata <= {4'b0, it.rot, it.vy, it.vx, it.qw, it.qz, it.qy, it.qx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (wheel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SPEED_LIMIT) pred_limit = value[22:0];
        else if (addr == ADDR_ARM_FACTOR) pred_arm = value[7:0];
    endtask

    function automatic t_drive_item make_item(bit req, bit wide);
        t_drive_item it;
        it.req = req;
        it.qx = 16'($urandom_range(0, 32768)) - 16'sd16384;
        it.qy = 16'($urandom_range(0, 32768)) - 16'sd16384;
        it.qz = 16'($urandom_range(0, 32768)) - 16'sd16384;
        it.qw = 16'($urandom_range(0, 32768)) - 16'sd16384;
        if (wide) begin
            it.vx = 20'($urandom());
            it.vy = 20'($urandom());
            it.rot = 20'($urandom());
        end else begin
            it.vx = 20'($urandom_range(0, 60000)) - 20'sd30000;
            it.vy = 20'($urandom_range(0, 60000)) - 20'sd30000;
            it.rot = 20'($urandom_range(0, 2000)) - 20'sd1000;
        end
        return it;
    endfunction

    task automatic send_quat(input int qx, qy, qz, qw);
        t_drive_item it;
        it = make_item(REQ_ORIENT, 1'b1);
        it.qx = 16'(qx);
        it.qy = 16'(qy);
        it.qz = 16'(qz);
        it.qw = 16'(qw);
        send_item(it);
    endtask

    task automatic send_cmd(input int vx, vy, rot);
        t_drive_item it;
        it = make_item(REQ_COMMAND, 1'b0);
        it.vx = 20'(vx);
        it.vy = 20'(vy);
        it.rot = 20'(rot);
        send_item(it);
    endtask

    task automatic test_reset_heading();
        send_cmd(256, 0, 0);
        send_cmd(0, -256, 3);
        send_cmd(524287, -524288, 0);
    endtask

    task automatic test_orientation_cases();
        send_quat(0, 0, 11585, 11585);      // 90 deg about z
        send_cmd(2560, 1280, 0);
        send_quat(0, 0, 16384, 0);          // 180 deg, negative denominator
        send_cmd(2560, 1280, 10);
        send_quat(1000, 8192, 8192, -1000); // both atan2 operands zero
        send_cmd(-2560, 768, 0);
        send_quat(16384, 16384, 16384, 16384);
        send_cmd(1000, 1000, -5);
        send_quat(-16384, -16384, -16384, -16384);
        send_cmd(-1000, 2000, 0);
        send_quat(-16384, 16384, -16384, 16384);
        send_cmd(300, -300, 7);
    endtask

    task automatic test_register_extremes();
        write_reg(ADDR_SPEED_LIMIT, 32'd0);
        send_cmd(524287, 524287, 524287);
        write_reg(ADDR_SPEED_LIMIT, 32'h007F_FFFF);
        write_reg(ADDR_ARM_FACTOR, 32'd255);
        send_cmd(524287, 524287, 524287);
        send_cmd(-524288, -524288, -524288);
        write_reg(ADDR_ARM_FACTOR, 32'd0);
        send_cmd(-524288, 524287, 524287);
        send_cmd(0, 0, -524288);
    endtask

    task automatic test_backpressure();
        hold_req = hold_req + 1;
        for (int n = 0; n < 12; n++) send_item(make_item(n % 4 == 0 ? REQ_ORIENT : REQ_COMMAND,
                                                         1'b0));
        wait_idle();
        for (int n = 0; n < 6; n++) send_item(make_item(REQ_COMMAND, 1'b0));
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
            send_item(make_item($urandom_range(0, 9) < 6, $urandom_range(0, 4) == 0));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_heading();
        test_orientation_cases();
        test_register_extremes();
        write_reg(ADDR_SPEED_LIMIT, 32'd43520);
        write_reg(ADDR_ARM_FACTOR, 32'd10);
        idle_on = 1'b1;
        test_backpressure();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(ADDR_SPEED_LIMIT, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 60000));
            write_reg(ADDR_ARM_FACTOR, $urandom_range(0, 255));
            test_random_mix(110);
        end
        write_reg(ADDR_SPEED_LIMIT, 32'h007F_FFFF);
        write_reg(ADDR_ARM_FACTOR, 32'd1);
        idle_on = 1'b0;
        test_random_mix(90);
        wait_idle();
        $display("covered %0d orientation and %0d command beats, %0d wheel beats checked",
                 n_orient, n_cmd, n_wheel_beats);
        $display("register extremes, degenerate and unnormalised quaternions, long output hold");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[omni_three_wheel_field_kinematics_unit.f]
src/otwfk_pkg.sv
src/otwfk_ctrl.sv
src/otwfk_dp.sv
src/omni_three_wheel_field_kinematics_unit.sv
verif/omni_three_wheel_field_kinematics_unit_tb.sv
